/* hw/rtl/gbcc_pkg.sv */
// ----------------------------------------------------------------------------
// gbcc_pkg - shared types and constants for the grid collision engine
// Request codes, field widths and default grid geometry.
// ----------------------------------------------------------------------------
package gbcc_pkg;
   localparam int COORD_W = 15;
   localparam int RAD_W = 10;
   localparam int FRAC_BITS = 4;
   localparam int FILL_W = 4;
   localparam int DEF_GRID_COLS = 24;
   localparam int DEF_GRID_ROWS = 14;
   localparam int DEF_CELL_CAPACITY = 8;
   localparam int DEF_CELL_SHIFT = 4;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic CSR_ITEM_RADIUS = 1'b0;
   localparam logic CSR_PROBE_RADIUS = 1'b1;
endpackage

/* hw/rtl/grid_binned_circle_collision.sv */
// ----------------------------------------------------------------------------
// grid_binned_circle_collision - uniform grid broad-phase collision engine
// Stores points in grid cells and answers radius overlap queries.
// ----------------------------------------------------------------------------
// Usage: req_ words carry a request type (clear, insert, query) and a point.
// Each request yields exactly one rsp_ word: hit, cells_touched, cells_full.
// Cell fill counts and entry coordinates live in synchronous RAMs with
// registered reads. One request is processed at a time.
// Steps: clear sweeps the fill RAM, one cell per cycle. Insert visits each
// distinct cell in turn (read fill, wait, write). Query visits each cell
// (read fill, wait), then scans its stored entries (entry read, square
// stage, compare) and ends at the first hit. The entry RAM port and fill
// RAM read set the rate.
// Reset: radii return to 48 and 64, and a fill-clearing sweep runs first;
// one request may be taken into the input register meanwhile and waits
// for the sweep to end.
// A stalled receiver: the result is held in the rsp_ register; the next
// request is accepted into the input register meanwhile, and starts once
// the result slot is free.
// ----------------------------------------------------------------------------
module grid_binned_circle_collision #(
   parameter int GRID_COLS = gbcc_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS = gbcc_pkg::DEF_GRID_ROWS,
   parameter int CELL_CAPACITY = gbcc_pkg::DEF_CELL_CAPACITY,
   parameter int CELL_SHIFT = gbcc_pkg::DEF_CELL_SHIFT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_type,
   input  logic signed [gbcc_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [gbcc_pkg::COORD_W-1:0] req_pos_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit,
   output logic [2:0] rsp_cells_touched,
   output logic [2:0] rsp_cells_full,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [gbcc_pkg::RAD_W-1:0] csr_data
);
   localparam int CW = gbcc_pkg::COORD_W;
   localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
   localparam int NUM_ENT = NUM_CELLS * CELL_CAPACITY;
   localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int ENT_W = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
   localparam int SLOT_W = gbcc_pkg::FILL_W;
   localparam int D_W = CW + 1;          // difference width
   localparam int SQ_W = 2 * D_W;        // square width
   localparam int LIM_W = 2 * (gbcc_pkg::RAD_W + 1);

   typedef enum logic [10:0] {
      ST_INIT   = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_CLEAR  = 11'b00000000100,
      ST_CORNER = 11'b00000001000,
      ST_FRD    = 11'b00000010000,
      ST_FWAIT  = 11'b00000100000,
      ST_FUPD   = 11'b00001000000,
      ST_ERD    = 11'b00010000000,
      ST_EWAIT  = 11'b00100000000,
      ST_ECMP   = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [gbcc_pkg::RAD_W-1:0] item_r_ff, probe_r_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         item_r_ff <= gbcc_pkg::RAD_W'(48);
         probe_r_ff <= gbcc_pkg::RAD_W'(64);
      end else if (csr_write) begin
         if (csr_index == gbcc_pkg::CSR_ITEM_RADIUS) item_r_ff <= csr_data;
         else probe_r_ff <= csr_data;
      end
   end

   // input skid register
   logic in_full_ff;
   logic [1:0] in_type_ff;
   logic signed [CW-1:0] in_x_ff, in_y_ff;
   logic take;  // core picks up the buffered word
   assign req_ready = !in_full_ff;
   always_ff @(posedge clock) begin
      if (reset) in_full_ff <= 1'b0;
      else if (req_valid && req_ready) in_full_ff <= 1'b1;
      else if (take) in_full_ff <= 1'b0;
      if (req_valid && req_ready) begin
         in_type_ff <= req_type;
         in_x_ff <= req_pos_x;
         in_y_ff <= req_pos_y;
      end
   end

   // working registers
   logic [1:0] op_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic [CELL_W-1:0] cells_ff [4];
   logic [2:0] ncell_ff, k_ff, full_ff;
   logic hit_ff;
   logic [SLOT_W-1:0] fill_ff, s_ff;
   logic [CELL_W-1:0] sweep_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [SQ_W:0] d2_ff;

   // corner mapping
   logic [gbcc_pkg::RAD_W-1:0] rad;
   logic signed [CW+1:0] cx [4], cy [4];
   logic [COL_W-1:0] col [4];
   logic [ROW_W-1:0] row [4];
   logic [CELL_W-1:0] cidx [4];
   assign rad = (op_ff == gbcc_pkg::REQ_INSERT) ? item_r_ff : probe_r_ff;
   for (genvar g = 0; g < 4; g++) begin : g_corner
      always_comb begin
         cx[g] = (g % 2 == 1) ? (CW+2)'(x_ff) + (CW+2)'(rad) : (CW+2)'(x_ff) - (CW+2)'(rad);
         cy[g] = (g / 2 == 1) ? (CW+2)'(y_ff) + (CW+2)'(rad) : (CW+2)'(y_ff) - (CW+2)'(rad);
      end
      gbcc_cell_map #(.LIMIT(GRID_COLS), .CELL_SHIFT(CELL_SHIFT), .IDX_W(COL_W))
         u_col (.coord(cx[g]), .idx(col[g]));
      gbcc_cell_map #(.LIMIT(GRID_ROWS), .CELL_SHIFT(CELL_SHIFT), .IDX_W(ROW_W))
         u_row (.coord(cy[g]), .idx(row[g]));
      assign cidx[g] = CELL_W'(CELL_W'(row[g]) * CELL_W'(GRID_COLS) + CELL_W'(col[g]));
   end

   // dedup into ordered list
   logic [CELL_W-1:0] list [4];
   logic [2:0] nlist;
   always_comb begin
      logic seen;
      for (int i = 0; i < 4; i++) list[i] = '0;
      nlist = '0;
      for (int k = 0; k < 4; k++) begin
         seen = 1'b0;
         for (int j = 0; j < 4; j++)
            if (3'(j) < nlist && list[j] == cidx[k]) seen = 1'b1;
         if (!seen) begin
            list[nlist[1:0]] = cidx[k];
            nlist = nlist + 3'd1;
         end
      end
   end

   // fill RAM
   logic [SLOT_W-1:0] fill_mem [NUM_CELLS];
   logic fill_we;
   logic [CELL_W-1:0] fill_waddr;
   logic [SLOT_W-1:0] fill_wdata, fill_rdata;
   logic [CELL_W-1:0] cur_cell;
   assign cur_cell = cells_ff[k_ff[1:0]];
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
      fill_rdata <= fill_mem[cur_cell];
   end

   // entry RAM (x and y side by side)
   logic [2*CW-1:0] ent_mem [NUM_ENT];
   logic ent_we;
   logic [ENT_W-1:0] ent_addr_w, ent_addr_r;
   logic [2*CW-1:0] ent_rdata;
   assign ent_addr_w = ENT_W'(ENT_W'(cur_cell) * ENT_W'(CELL_CAPACITY) + ENT_W'(fill_ff));
   assign ent_addr_r = ENT_W'(ENT_W'(cur_cell) * ENT_W'(CELL_CAPACITY) + ENT_W'(s_ff));
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_addr_w] <= {x_ff, y_ff};
      ent_rdata <= ent_mem[ent_addr_r];
   end

   // distance stage: sum of squares registered before compare
   logic signed [D_W-1:0] dx, dy;
   logic signed [CW-1:0] ex, ey;
   logic [SQ_W-1:0] sqx, sqy;
   assign ex = ent_rdata[2*CW-1:CW];
   assign ey = ent_rdata[CW-1:0];
   assign dx = D_W'(ex) - D_W'(x_ff);
   assign dy = D_W'(ey) - D_W'(y_ff);
   assign sqx = SQ_W'(dx) * SQ_W'(dx);
   assign sqy = SQ_W'(dy) * SQ_W'(dy);

   // result register
   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   logic done_now;

   logic [SLOT_W-1:0] fill_cap;
   assign fill_cap = (fill_rdata > SLOT_W'(CELL_CAPACITY)) ? SLOT_W'(CELL_CAPACITY) : fill_rdata;

   always_comb begin
      state_in = state_ff;
      take = 1'b0;
      fill_we = 1'b0;
      fill_waddr = cur_cell;
      fill_wdata = fill_ff + SLOT_W'(1);
      ent_we = 1'b0;
      done_now = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            fill_we = 1'b1;
            fill_waddr = sweep_ff;
            fill_wdata = '0;
            if (sweep_ff == CELL_W'(NUM_CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (in_full_ff && !rsp_valid_ff) begin
            take = 1'b1;
            unique case (in_type_ff) inside
               gbcc_pkg::REQ_CLEAR: state_in = ST_CLEAR;
               gbcc_pkg::REQ_INSERT, gbcc_pkg::REQ_QUERY: state_in = ST_CORNER;
               default: state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            fill_we = 1'b1;
            fill_waddr = sweep_ff;
            fill_wdata = '0;
            if (sweep_ff == CELL_W'(NUM_CELLS - 1)) state_in = ST_DONE;
         end
         ST_CORNER: state_in = ST_FRD;
         ST_FRD: state_in = ST_FWAIT;
         ST_FWAIT: begin
            if (op_ff == gbcc_pkg::REQ_INSERT) state_in = ST_FUPD;
            else if (fill_cap == '0)
               state_in = (k_ff + 3'd1 == ncell_ff) ? ST_DONE : ST_FRD;
            else state_in = ST_ERD;
         end
         ST_FUPD: begin
            if (fill_ff < SLOT_W'(CELL_CAPACITY)) begin
               fill_we = 1'b1;
               ent_we = 1'b1;
            end
            state_in = (k_ff + 3'd1 == ncell_ff) ? ST_DONE : ST_FRD;
         end
         ST_ERD: state_in = ST_EWAIT;
         ST_EWAIT: state_in = ST_ECMP;
         ST_ECMP: begin
            if (d2_ff < (SQ_W+1)'(lim_ff)) state_in = ST_DONE;
            else if (s_ff + SLOT_W'(1) < fill_ff) state_in = ST_ERD;
            else if (k_ff + 3'd1 == ncell_ff) state_in = ST_DONE;
            else state_in = ST_FRD;
         end
         ST_DONE: begin
            done_now = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [gbcc_pkg::RAD_W:0] rsum;
   assign rsum = (gbcc_pkg::RAD_W+1)'(item_r_ff) + (gbcc_pkg::RAD_W+1)'(probe_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INIT || state_ff == ST_CLEAR)
            sweep_ff <= (sweep_ff == CELL_W'(NUM_CELLS - 1)) ? '0 : sweep_ff + CELL_W'(1);
         if (done_now) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: if (take) begin
            op_ff <= in_type_ff;
            x_ff <= in_x_ff;
            y_ff <= in_y_ff;
            k_ff <= '0;
            full_ff <= '0;
            hit_ff <= 1'b0;
            ncell_ff <= '0;
         end
         ST_CORNER: begin
            cells_ff <= list;
            ncell_ff <= nlist;
            lim_ff <= LIM_W'(rsum) * LIM_W'(rsum);
         end
         ST_FWAIT: begin
            fill_ff <= (op_ff == gbcc_pkg::REQ_INSERT) ? fill_rdata : fill_cap;
            s_ff <= '0;
            if (op_ff != gbcc_pkg::REQ_INSERT && fill_cap == '0) k_ff <= k_ff + 3'd1;
         end
         ST_FUPD: begin
            if (fill_ff >= SLOT_W'(CELL_CAPACITY)) full_ff <= full_ff + 3'd1;
            k_ff <= k_ff + 3'd1;
         end
         ST_EWAIT: d2_ff <= (SQ_W+1)'(sqx) + (SQ_W+1)'(sqy);
         ST_ECMP: begin
            if (d2_ff < (SQ_W+1)'(lim_ff)) hit_ff <= 1'b1;
            else if (s_ff + SLOT_W'(1) < fill_ff) s_ff <= s_ff + SLOT_W'(1);
            else k_ff <= k_ff + 3'd1;
         end
         ST_DONE: begin
            rsp_hit <= hit_ff;
            rsp_cells_touched <= ncell_ff;
            rsp_cells_full <= full_ff;
         end
         default: ;
      endcase
   end
endmodule

/* hw/rtl/gbcc_cell_map.sv */
// ----------------------------------------------------------------------------
// gbcc_cell_map - corner to cell index
// Shifts a corner coordinate down to a grid coordinate and clamps it.
// ----------------------------------------------------------------------------
module gbcc_cell_map #(
   parameter int LIMIT = gbcc_pkg::DEF_GRID_COLS,
   parameter int CELL_SHIFT = gbcc_pkg::DEF_CELL_SHIFT,
   parameter int IDX_W = 5
) (
   input  logic signed [gbcc_pkg::COORD_W+1:0] coord,
   output logic [IDX_W-1:0]                    idx
);
   localparam int CW = gbcc_pkg::COORD_W + 2;
   logic signed [CW-1:0] shifted;
   always_comb begin
      shifted = coord >>> (gbcc_pkg::FRAC_BITS + CELL_SHIFT);
      if (coord < 0)
         idx = '0;
      else if (shifted > CW'(LIMIT - 1))
         idx = IDX_W'(LIMIT - 1);
      else
         idx = IDX_W'(shifted);
   end
endmodule

/* tb/tb_grid_binned_circle_collision.sv */
// ----------------------------------------------------------------------------
// tb_grid_binned_circle_collision - self-checking bench for the grid engine
// Drives clear, insert, query and unused-code words with random pacing on
// both channels, predicts each response from a local copy of the grid, and compares.
// ----------------------------------------------------------------------------
module tb_grid_binned_circle_collision;
   import gbcc_pkg::*;

   localparam int COLS = DEF_GRID_COLS;
   localparam int ROWS = DEF_GRID_ROWS;
   localparam int CAP = DEF_CELL_CAPACITY;
   localparam int SHIFT = DEF_CELL_SHIFT;
   localparam int NCELL = COLS * ROWS;
   localparam int N_RAND = 1330;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic       hit;
      logic [2:0] touched;
      logic [2:0] full;
   } rsp_t;

   typedef struct {
      logic [1:0] kind;
      int         x;
      int         y;
      logic       known;   // expected response typed in below
      rsp_t       rsp;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = REQ_CLEAR;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [2:0] rsp_cells_touched;
   logic [2:0] rsp_cells_full;
   logic csr_write = 1'b0;
   logic csr_index = CSR_ITEM_RADIUS;
   logic [RAD_W-1:0] csr_data = '0;

   always #10 clock = ~clock;

   grid_binned_circle_collision u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_cells_touched(rsp_cells_touched), .rsp_cells_full(rsp_cells_full),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // ---- local grid model ----
   int unsigned item_rad, probe_rad;
   int fill [NCELL];
   int ent_x [NCELL*CAP];
   int ent_y [NCELL*CAP];

   rsp_t expected_rsps [$];
   int   n_errors = 0;
   int   n_checked = 0;
   int   n_hits = 0;
   int   n_full = 0;
   int   cycles = 0;

   // Corner to cell index: arithmetic shift, clamped onto the grid edges.
   function automatic int cell_of(int c, int lim);
      int idx;
      if (c < 0) return 0;
      idx = c >>> (FRAC_BITS + SHIFT);
      if (idx > lim - 1) idx = lim - 1;
      return idx;
   endfunction

   // Distinct cells under the four box corners, in corner order.
   function automatic int box_cells(int x, int y, int r, output int lst [4]);
      int n, cx, cy, c;
      bit dup;
      n = 0;
      for (int k = 0; k < 4; k++) begin
         cx = (k & 1) ? x + r : x - r;
         cy = (k & 2) ? y + r : y - r;
         c = cell_of(cy, ROWS) * COLS + cell_of(cx, COLS);
         dup = 1'b0;
         for (int j = 0; j < n; j++) if (lst[j] == c) dup = 1'b1;
         if (!dup) begin
            lst[n] = c;
            n++;
         end
      end
      return n;
   endfunction

   function automatic rsp_t predict_grid(logic [1:0] kind, int x, int y);
      rsp_t r;
      int lst [4];
      int n, c, e;
      longint lim, dx, dy;
      r = '0;
      case (kind)
         REQ_CLEAR: begin
            for (int i = 0; i < NCELL; i++) fill[i] = 0;
         end
         REQ_INSERT: begin
            n = box_cells(x, y, int'(item_rad), lst);
            r.touched = 3'(n);
            for (int k = 0; k < n; k++) begin
               c = lst[k];
               if (fill[c] < CAP) begin
                  e = c * CAP + fill[c];
                  ent_x[e] = x;
                  ent_y[e] = y;
                  fill[c]++;
               end else begin
                  r.full++;
               end
            end
         end
         REQ_QUERY: begin
            lim = longint'(item_rad + probe_rad) * longint'(item_rad + probe_rad);
            n = box_cells(x, y, int'(probe_rad), lst);
            r.touched = 3'(n);
            for (int k = 0; k < n; k++)
               for (int s = 0; s < fill[lst[k]]; s++) begin
                  e = lst[k] * CAP + s;
                  dx = ent_x[e] - x;
                  dy = ent_y[e] - y;
                  if (dx * dx + dy * dy < lim) r.hit = 1'b1;
               end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---- response checker ----
   always @(posedge clock) begin
      rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("ERROR: unexpected response word");
         end else begin
            want = expected_rsps.pop_front();
            n_checked++;
            if (rsp_hit) n_hits++;
            if (rsp_cells_full != 0) n_full++;
            if (rsp_hit !== want.hit || rsp_cells_touched !== want.touched ||
                rsp_cells_full !== want.full) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: word %0d exp hit=%0d touched=%0d full=%0d, got %b %0d %0d",
                           n_checked, want.hit, want.touched, want.full,
                           rsp_hit, rsp_cells_touched, rsp_cells_full);
            end
         end
      end
   end

   // ---- receiver: random stalls per word, with quiet stretches ----
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Hands one word to the block, predicting its response at acceptance.
   // Valid stays high into the next word when there is no gap.
   task automatic send_word(logic [1:0] kind, int x, int y, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_pos_x <= x[COORD_W-1:0];
      req_pos_y <= y[COORD_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_grid(kind, x, y));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);   // idle pause once every response is back
   endtask

   task automatic write_csr(logic idx, int unsigned val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[RAD_W-1:0];
      if (idx == CSR_ITEM_RADIUS) item_rad = val;
      else probe_rad = val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 32767) - 16384;        // full range
         1: return $urandom_range(0, 1) ? 16383 : -16384;
         default: return $urandom_range(0, COLS * 256 + 200) - 100; // on the grid and just past its edges
      endcase
   endfunction

   stim_row_t rows [$];

   function automatic stim_row_t row(logic [1:0] k, int x, int y, logic kn = 0,
                                      rsp_t r = '0);
      stim_row_t s;
      s.kind = k; s.x = x; s.y = y; s.known = kn; s.rsp = r;
      return s;
   endfunction

   initial begin
      int unsigned radii [5];
      logic [1:0] kind;
      int cx, cy;
      radii = '{0, 1, 48, 300, 1023};
      item_rad = 48;
      probe_rad = 64;
      for (int i = 0; i < NCELL; i++) fill[i] = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty grid, clamped corners, unused code, radius-sum edge, overflow, clear.
      rows.push_back(row(REQ_QUERY, 100, 100, 1, '{1'b0, 3'd1, 3'd0}));
      rows.push_back(row(REQ_INSERT, -16384, -16384, 1, '{1'b0, 3'd1, 3'd0}));
      rows.push_back(row(REQ_INSERT, 16383, 16383, 1, '{1'b0, 3'd1, 3'd0}));
      rows.push_back(row(REQ_INSERT, 16383, -16384));
      rows.push_back(row(REQ_INSERT, 256, 256, 1, '{1'b0, 3'd4, 3'd0}));
      rows.push_back(row(REQ_QUERY, 256, 256, 1, '{1'b1, 3'd4, 3'd0}));
      rows.push_back(row(REQ_QUERY, -16384, 16383));
      rows.push_back(row(REQ_UNUSED, 256, 256, 1, '{1'b0, 3'd0, 3'd0}));
      rows.push_back(row(REQ_QUERY, 256 + 112, 256));  // exactly at radius sum
      rows.push_back(row(REQ_QUERY, 256 + 111, 256));
      for (int i = 0; i < 9; i++) rows.push_back(row(REQ_INSERT, 1000, 1000));
      rows.push_back(row(REQ_QUERY, 1000, 1000));
      rows.push_back(row(REQ_CLEAR, 5, 5, 1, '{1'b0, 3'd0, 3'd0}));
      rows.push_back(row(REQ_QUERY, 256, 256, 1, '{1'b0, 3'd4, 3'd0}));

      foreach (rows[i]) begin
         send_word(rows[i].kind, rows[i].x, rows[i].y, $urandom_range(0, 2));
         if (rows[i].known && expected_rsps[$] !== rows[i].rsp) begin
            n_errors++;
            $display("ERROR: directed row %0d disagrees with the typed value", i);
         end
      end
      drain();   // sender holds off until all responses are back

      // Random phases; radii move between phases, extremes included.
      for (int p = 0; p < 10; p++) begin
         write_csr(CSR_ITEM_RADIUS, (p < 5) ? radii[p] : $urandom_range(0, 1023));
         write_csr(CSR_PROBE_RADIUS, (p < 5) ? radii[4 - p] : $urandom_range(0, 1023));
         cx = $urandom_range(0, COLS * 256);
         cy = $urandom_range(0, ROWS * 256);
         for (int i = 0; i < N_RAND / 10; i++) begin
            case ($urandom_range(0, 39))
               0: kind = REQ_CLEAR;
               1: kind = REQ_UNUSED;
               default: kind = $urandom_range(0, 1) ? REQ_INSERT : REQ_QUERY;
            endcase
            // half the points cluster near one spot so queries find hits
            if ($urandom_range(0, 1))
               send_word(kind, cx + $urandom_range(0, 600) - 300,
                         cy + $urandom_range(0, 600) - 300,
                         (i % 100 < 20) ? 0 : $urandom_range(0, 14));
            else
               send_word(kind, rand_coord(), rand_coord(),
                         (i % 100 < 20) ? 0 : $urandom_range(0, 14));
         end
         drain();
      end

      $display("covered %0d responses over 10 radius settings: %0d hits, %0d with full cells",
               n_checked, n_hits, n_full);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("mismatches: %0d, outstanding: %0d", n_errors, expected_rsps.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule
